### rtl/great_circle_distance_and_course_defines.svh
// assertion macros for the great-circle distance and course block
`ifndef GREAT_CIRCLE_DISTANCE_AND_COURSE_DEFINES_SVH
`define GREAT_CIRCLE_DISTANCE_AND_COURSE_DEFINES_SVH

// same-cycle implication
`define GCDC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gcdc check failed");

// next-cycle implication
`define GCDC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gcdc check failed");

`endif

### rtl/gcdc_pkg.sv
// shared types, constants and constant functions for the great-circle block
package gcdc_pkg;

   localparam int VEC_W        = 34;
   localparam int FRAC         = 30;
   localparam int DIST_W       = 30;
   localparam int TOL_W        = 16;
   localparam int NMI_PER_TURN = 21600;
   localparam int NMI_W        = 15;
   localparam int QUEUE_DEPTH  = 4;
   localparam int QPTR_W       = 2;
   localparam int QCNT_W       = 3;
   localparam logic [63:0] INV_TWO_PI_Q64 = 64'h28BE60DB9391054A;
   localparam logic [DIST_W-1:0] DIST_MAX = 30'd707788800;

   localparam logic [1:0] CASE_GENERAL  = 2'd0;
   localparam logic [1:0] CASE_COINCIDE = 2'd1;
   localparam logic [1:0] CASE_MERIDIAN = 2'd2;

   typedef struct packed {
      logic [1:0] ccase;
      logic       half;
   } cls_type;

   // atan(2^-idx) in binary angle units of an aw-bit turn, truncated series
   function automatic longint atan_entry(input int idx, input int aw);
      logic [63:0] p;
      logic [63:0] s;
      logic [63:0] term;
      int          k;
      s = 64'd0;
      k = 0;
      p = INV_TWO_PI_Q64 >> idx;
      if (idx == 0) begin
         return longint'(64'd1 << (aw - 3));
      end
      for (int n = 0; n < 40; n++) begin
         if (p != 64'd0) begin
            term = p / 64'(2 * k + 1);
            if (k[0]) s = s - term;
            else s = s + term;
            p = (2 * idx < 64) ? (p >> (2 * idx)) : 64'd0;
            k++;
         end
      end
      return longint'(s >> (64 - aw));
   endfunction

   // cordic gain times 2^30 after ns vectoring steps on (2^30, 0)
   function automatic longint kx_of(input int ns);
      longint x;
      longint y;
      longint xs;
      longint ys;
      x = longint'(1) << FRAC;
      y = 0;
      for (int n = 0; n < 64; n++) begin
         if (n < ns) begin
            xs = x >>> n;
            ys = y >>> n;
            if (y < 0) begin
               x = x - ys;
               y = y + xs;
            end else begin
               x = x + ys;
               y = y - xs;
            end
         end
      end
      return x;
   endfunction

   // q30 product, floor shift
   function automatic logic signed [VEC_W-1:0] mulq(input logic signed [VEC_W-1:0] a,
                                                    input logic signed [VEC_W-1:0] b);
      logic signed [2*VEC_W-1:0] p;
      p = a * b;
      return p[FRAC +: VEC_W];
   endfunction

endpackage

### rtl/gcdc_front.sv
// front stage: takes requests, saturates latitudes, wraps longitude, classifies
module gcdc_front #(
   parameter int ANGLE_WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [ANGLE_WIDTH-1:0]       req_lat_start,
   input  logic signed [ANGLE_WIDTH-1:0]       req_lon_start,
   input  logic signed [ANGLE_WIDTH-1:0]       req_lat_end,
   input  logic signed [ANGLE_WIDTH-1:0]       req_lon_end,
   input  logic                                csr_write,
   input  logic [gcdc_pkg::TOL_W-1:0]          csr_angle_tolerance,
   input  logic                                q_full,
   output logic                                push_valid,
   output logic signed [ANGLE_WIDTH-1:0]       lat1,
   output logic signed [ANGLE_WIDTH-1:0]       lat2,
   output logic signed [ANGLE_WIDTH-1:0]       dlon,
   output gcdc_pkg::cls_type                   cls
);
   import gcdc_pkg::*;

   localparam int AW = ANGLE_WIDTH;
   localparam logic signed [AW-1:0] QTR = {2'b01, {(AW-2){1'b0}}};

   logic [TOL_W-1:0]       tol_ff;
   logic                   valid_ff, valid_in;
   logic signed [AW-1:0]   lat1_ff, lat1_in;
   logic signed [AW-1:0]   lat2_ff, lat2_in;
   logic signed [AW-1:0]   dlon_ff, dlon_in;
   cls_type                cls_ff, cls_in;
   logic                   load;

   assign load      = !valid_ff || !q_full;
   assign req_stall = !load;
   assign valid_in  = req_valid;

   always_comb begin
      logic signed [AW:0] dl_ext;
      logic [AW:0]        dl_abs;
      logic signed [AW:0] ld;
      logic [AW:0]        ld_abs;
      logic [AW:0]        tol_ext;
      logic               lon_zero;
      logic               lat_zero;
      lat1_in = (req_lat_start > QTR) ? QTR : (req_lat_start < -QTR) ? -QTR : req_lat_start;
      lat2_in = (req_lat_end > QTR) ? QTR : (req_lat_end < -QTR) ? -QTR : req_lat_end;
      dlon_in = req_lon_end - req_lon_start;
      dl_ext  = {dlon_in[AW-1], dlon_in};
      dl_abs  = dl_ext[AW] ? unsigned'(-dl_ext) : unsigned'(dl_ext);
      ld      = {lat1_in[AW-1], lat1_in} - {lat2_in[AW-1], lat2_in};
      ld_abs  = ld[AW] ? unsigned'(-ld) : unsigned'(ld);
      tol_ext = {{(AW-15){1'b0}}, tol_ff};
      lon_zero = dl_abs <= tol_ext;
      lat_zero = ld_abs <= tol_ext;
      cls_in.half = 1'b0;
      priority if (lon_zero && lat_zero) begin
         cls_in.ccase = CASE_COINCIDE;
      end else if (lon_zero) begin
         cls_in.ccase = CASE_MERIDIAN;
         priority if (lat1_in > 0 && lat2_in < 0) cls_in.half = 1'b1;
         else if (lat1_in < 0 && lat2_in > 0) cls_in.half = 1'b0;
         else if (lat1_in < lat2_in) cls_in.half = 1'b0;
         else cls_in.half = 1'b1;
      end else begin
         cls_in.ccase = CASE_GENERAL;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         tol_ff   <= '0;
      end else begin
         if (load) valid_ff <= valid_in;
         if (csr_write) tol_ff <= csr_angle_tolerance;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         lat1_ff <= lat1_in;
         lat2_ff <= lat2_in;
         dlon_ff <= dlon_in;
         cls_ff  <= cls_in;
      end
   end

   assign push_valid = valid_ff;
   assign lat1       = lat1_ff;
   assign lat2       = lat2_ff;
   assign dlon       = dlon_ff;
   assign cls        = cls_ff;

endmodule

### rtl/gcdc_queue.sv
// short fifo between the front and back parts
module gcdc_queue #(
   parameter int DATA_WIDTH = 99
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   input  logic [DATA_WIDTH-1:0] push_data,
   output logic                  full,
   input  logic                  pop_take,
   output logic                  pop_valid,
   output logic [DATA_WIDTH-1:0] pop_data
);
   import gcdc_pkg::*;

   logic [DATA_WIDTH-1:0] mem [QUEUE_DEPTH];
   logic [QPTR_W-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0]     count_ff, count_in;
   logic                  push, pop;

   assign full      = count_ff == QCNT_W'(QUEUE_DEPTH);
   assign pop_valid = count_ff != '0;
   assign push      = push_valid && !full;
   assign pop       = pop_take && pop_valid;
   assign count_in  = count_ff + QCNT_W'(push) - QCNT_W'(pop);
   assign pop_data  = mem[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop) rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem[wr_ptr_ff] <= push_data;
   end

endmodule

### rtl/gcdc_cordic.sv
// pipelined cordic, rotation or vectoring, one step per stage
module gcdc_cordic #(
   parameter int ANGLE_WIDTH   = 32,
   parameter int CORDIC_STAGES = 32,
   parameter bit VECTOR_MODE   = 1'b0,
   parameter int SIDE_WIDTH    = 1
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                en,
   input  logic signed [gcdc_pkg::VEC_W-1:0]   x_in,
   input  logic signed [gcdc_pkg::VEC_W-1:0]   y_in,
   input  logic signed [ANGLE_WIDTH-1:0]       z_in,
   input  logic [SIDE_WIDTH-1:0]               side_in,
   output logic signed [gcdc_pkg::VEC_W-1:0]   x_out,
   output logic signed [gcdc_pkg::VEC_W-1:0]   y_out,
   output logic signed [ANGLE_WIDTH+1:0]       z_out,
   output logic [SIDE_WIDTH-1:0]               side_out
);
   import gcdc_pkg::*;

   localparam int AW = ANGLE_WIDTH;
   localparam int NS = CORDIC_STAGES;
   localparam int ZW = AW + 2;
   localparam logic signed [ZW-1:0] HALF_Z = {3'b001, {(AW-1){1'b0}}};
   localparam logic signed [ZW-1:0] QTR_Z  = {4'b0001, {(AW-2){1'b0}}};

   logic signed [VEC_W-1:0] x_ff [NS+1];
   logic signed [VEC_W-1:0] y_ff [NS+1];
   logic signed [ZW-1:0]    z_ff [NS+1];
   logic                    flag_ff [NS+1];
   logic [SIDE_WIDTH-1:0]   side_ff [NS+1];

   logic signed [VEC_W-1:0] x0_in, y0_in;
   logic signed [ZW-1:0]    z0_in;
   logic                    flag0_in;

   // vectoring: flag marks the zero vector; rotation: flag marks a half-turn fold
   always_comb begin
      logic signed [ZW-1:0] z_ext;
      z_ext = {{2{z_in[AW-1]}}, z_in};
      x0_in = x_in;
      y0_in = y_in;
      z0_in = z_ext;
      flag0_in = 1'b0;
      if (VECTOR_MODE) begin
         flag0_in = (x_in == '0) && (y_in == '0);
         if (x_in < 0) begin
            x0_in = -x_in;
            y0_in = -y_in;
            z0_in = HALF_Z;
         end else begin
            z0_in = '0;
         end
      end else begin
         priority if (z_ext > QTR_Z) begin
            z0_in = z_ext - HALF_Z;
            flag0_in = 1'b1;
         end else if (z_ext < -QTR_Z) begin
            z0_in = z_ext + HALF_Z;
            flag0_in = 1'b1;
         end else begin
            z0_in = z_ext;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0]    <= x0_in;
         y_ff[0]    <= y0_in;
         z_ff[0]    <= z0_in;
         flag_ff[0] <= flag0_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) side_ff[0] <= '0;
      else if (en) side_ff[0] <= side_in;
   end

   for (genvar i = 0; i < NS; i++) begin : g_stage
      localparam logic signed [ZW-1:0] ATAN_I = ZW'(gcdc_pkg::atan_entry(i, AW));
      logic signed [VEC_W-1:0] xs, ys;
      logic                    dir;

      assign xs  = x_ff[i] >>> i;
      assign ys  = y_ff[i] >>> i;
      assign dir = VECTOR_MODE ? (y_ff[i] < 0) : (z_ff[i] >= 0);

      always_ff @(posedge clock) begin
         if (en) begin
            if (dir) begin
               x_ff[i+1] <= x_ff[i] - ys;
               y_ff[i+1] <= y_ff[i] + xs;
               z_ff[i+1] <= z_ff[i] - ATAN_I;
            end else begin
               x_ff[i+1] <= x_ff[i] + ys;
               y_ff[i+1] <= y_ff[i] - xs;
               z_ff[i+1] <= z_ff[i] + ATAN_I;
            end
            flag_ff[i+1] <= flag_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) side_ff[i+1] <= '0;
         else if (en) side_ff[i+1] <= side_ff[i];
      end
   end

   always_comb begin
      if (VECTOR_MODE) begin
         x_out = flag_ff[NS] ? '0 : x_ff[NS];
         y_out = y_ff[NS];
         z_out = flag_ff[NS] ? '0 : z_ff[NS];
      end else begin
         x_out = flag_ff[NS] ? -x_ff[NS] : x_ff[NS];
         y_out = flag_ff[NS] ? -y_ff[NS] : y_ff[NS];
         z_out = z_ff[NS];
      end
   end

   assign side_out = side_ff[NS];

endmodule

### rtl/gcdc_back.sv
// back part: sin/cos, chord terms, two arctangents, distance scaling, output register
module gcdc_back #(
   parameter int ANGLE_WIDTH   = 32,
   parameter int CORDIC_STAGES = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   output logic                                in_take,
   input  logic signed [ANGLE_WIDTH-1:0]       lat1,
   input  logic signed [ANGLE_WIDTH-1:0]       lat2,
   input  logic signed [ANGLE_WIDTH-1:0]       dlon,
   input  gcdc_pkg::cls_type                   cls,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [gcdc_pkg::DIST_W-1:0]         rsp_distance_nmi,
   output logic [ANGLE_WIDTH-1:0]              rsp_course_angle,
   output logic [1:0]                          rsp_course_case
);
   import gcdc_pkg::*;

   localparam int AW = ANGLE_WIDTH;
   localparam int ZW = AW + 2;
   localparam int CW = $bits(cls_type);
   localparam logic [AW-1:0]         HALF_A = {1'b1, {(AW-1){1'b0}}};
   localparam logic signed [ZW-1:0]  HALF_Z = {3'b001, {(AW-1){1'b0}}};
   localparam longint                KX     = gcdc_pkg::kx_of(CORDIC_STAGES);
   localparam logic signed [VEC_W-1:0] INVK = VEC_W'((longint'(1) << (2 * FRAC)) / KX);

   logic adv;

   // whole back pipeline moves together, held only by a full stalled output
   assign adv     = !rsp_valid || !rsp_stall;
   assign in_take = adv;

   logic signed [VEC_W-1:0] cp1, sp1, cp2, sp2, clon, slon;
   logic [CW:0]             r1_side;

   gcdc_cordic #(.ANGLE_WIDTH(AW), .CORDIC_STAGES(CORDIC_STAGES), .VECTOR_MODE(1'b0),
                 .SIDE_WIDTH(CW + 1)) u_rot_lat1 (
      .clock(clock), .reset(reset), .en(adv), .x_in(INVK), .y_in('0), .z_in(lat1),
      .side_in({cls, in_valid}), .x_out(cp1), .y_out(sp1), .z_out(), .side_out(r1_side));

   gcdc_cordic #(.ANGLE_WIDTH(AW), .CORDIC_STAGES(CORDIC_STAGES), .VECTOR_MODE(1'b0),
                 .SIDE_WIDTH(1)) u_rot_lat2 (
      .clock(clock), .reset(reset), .en(adv), .x_in(INVK), .y_in('0), .z_in(lat2),
      .side_in(1'b0), .x_out(cp2), .y_out(sp2), .z_out(), .side_out());

   gcdc_cordic #(.ANGLE_WIDTH(AW), .CORDIC_STAGES(CORDIC_STAGES), .VECTOR_MODE(1'b0),
                 .SIDE_WIDTH(1)) u_rot_dlon (
      .clock(clock), .reset(reset), .en(adv), .x_in(INVK), .y_in('0), .z_in(dlon),
      .side_in(1'b0), .x_out(clon), .y_out(slon), .z_out(), .side_out());

   // products
   logic signed [VEC_W-1:0] a_t0_ff, a_cs_ff, a_sc_ff, a_ss_ff, a_cc_ff, a_clon_ff;
   cls_type                 a_cls_ff;
   logic                    a_valid_ff;
   logic signed [VEC_W-1:0] b_t0_ff, b_cs_ff, b_ss_ff, b_scc_ff, b_ccc_ff;
   cls_type                 b_cls_ff;
   logic                    b_valid_ff;
   logic signed [VEC_W-1:0] c_t0_ff, c_t1_ff, c_t3_ff;
   cls_type                 c_cls_ff;
   logic                    c_valid_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         a_t0_ff   <= mulq(cp2, slon);
         a_cs_ff   <= mulq(cp1, sp2);
         a_sc_ff   <= mulq(sp1, cp2);
         a_ss_ff   <= mulq(sp1, sp2);
         a_cc_ff   <= mulq(cp1, cp2);
         a_clon_ff <= clon;
         a_cls_ff  <= cls_type'(r1_side[CW:1]);
         b_t0_ff   <= a_t0_ff;
         b_cs_ff   <= a_cs_ff;
         b_ss_ff   <= a_ss_ff;
         b_scc_ff  <= mulq(a_sc_ff, a_clon_ff);
         b_ccc_ff  <= mulq(a_cc_ff, a_clon_ff);
         b_cls_ff  <= a_cls_ff;
         c_t0_ff   <= b_t0_ff;
         c_t1_ff   <= b_cs_ff - b_scc_ff;
         c_t3_ff   <= b_ss_ff + b_ccc_ff;
         c_cls_ff  <= b_cls_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else if (adv) begin
         a_valid_ff <= r1_side[0];
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
      end
   end

   // chord magnitude and course angle in parallel
   logic signed [VEC_W-1:0] v1_m;
   logic [VEC_W+CW:0]       v1_side;
   logic signed [ZW-1:0]    v2_z;

   gcdc_cordic #(.ANGLE_WIDTH(AW), .CORDIC_STAGES(CORDIC_STAGES), .VECTOR_MODE(1'b1),
                 .SIDE_WIDTH(VEC_W + CW + 1)) u_vec_chord (
      .clock(clock), .reset(reset), .en(adv), .x_in(c_t0_ff), .y_in(c_t1_ff), .z_in('0),
      .side_in({c_t3_ff, c_cls_ff, c_valid_ff}), .x_out(v1_m), .y_out(), .z_out(),
      .side_out(v1_side));

   gcdc_cordic #(.ANGLE_WIDTH(AW), .CORDIC_STAGES(CORDIC_STAGES), .VECTOR_MODE(1'b1),
                 .SIDE_WIDTH(1)) u_vec_course (
      .clock(clock), .reset(reset), .en(adv), .x_in(c_t1_ff), .y_in(c_t0_ff), .z_in('0),
      .side_in(1'b0), .x_out(), .y_out(), .z_out(v2_z), .side_out());

   logic signed [VEC_W-1:0] d_t2_ff, d_t3_ff;
   logic [AW-1:0]           d_course_ff;
   cls_type                 d_cls_ff;
   logic                    d_valid_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         d_t2_ff     <= mulq(v1_m, INVK);
         d_t3_ff     <= v1_side[VEC_W+CW:CW+1];
         d_course_ff <= v2_z[AW-1:0];
         d_cls_ff    <= cls_type'(v1_side[CW:1]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) d_valid_ff <= 1'b0;
      else if (adv) d_valid_ff <= v1_side[0];
   end

   // central angle
   logic signed [ZW-1:0] v3_z;
   logic [AW+CW:0]       v3_side;

   gcdc_cordic #(.ANGLE_WIDTH(AW), .CORDIC_STAGES(CORDIC_STAGES), .VECTOR_MODE(1'b1),
                 .SIDE_WIDTH(AW + CW + 1)) u_vec_dist (
      .clock(clock), .reset(reset), .en(adv), .x_in(d_t3_ff), .y_in(d_t2_ff), .z_in('0),
      .side_in({d_course_ff, d_cls_ff, d_valid_ff}), .x_out(), .y_out(), .z_out(v3_z),
      .side_out(v3_side));

   logic [AW-1:0]         zc;
   logic [AW+NMI_W-1:0]   prod;
   logic [DIST_W-1:0]     dist_in;
   logic [AW-1:0]         course_in;
   cls_type               e_cls;

   always_comb begin
      priority if (v3_z < 0) zc = '0;
      else if (v3_z > HALF_Z) zc = HALF_A;
      else zc = v3_z[AW-1:0];
      prod    = {{NMI_W{1'b0}}, zc} * (AW+NMI_W)'(NMI_PER_TURN);
      dist_in = prod[AW-16 +: DIST_W];
      e_cls   = cls_type'(v3_side[CW:1]);
      if (e_cls.ccase == CASE_GENERAL) course_in = v3_side[AW+CW:CW+1];
      else course_in = e_cls.half ? HALF_A : '0;
   end

   logic [DIST_W-1:0] dist_ff;
   logic [AW-1:0]     course_ff;
   logic [1:0]        case_ff;
   logic              valid_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         dist_ff   <= dist_in;
         course_ff <= course_in;
         case_ff   <= e_cls.ccase;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else if (adv) valid_ff <= v3_side[0];
   end

   assign rsp_valid        = valid_ff;
   assign rsp_distance_nmi = dist_ff;
   assign rsp_course_angle = course_ff;
   assign rsp_course_case  = case_ff;

endmodule

### rtl/great_circle_distance_and_course.sv
// top level of the great-circle distance and initial course block
//
//  channel   direction  handshake          payload
//  req_      in         valid / stall      lat_start, lon_start, lat_end, lon_end
//  rsp_      out        valid / stall      distance_nmi, course_angle, course_case
//  csr_      in         valid / ready      angle_tolerance
//
//  one request per cycle sustained while rsp_stall does not hold the back pipeline; the
//  latency is set by the three cordic pipelines in series (sin/cos, chord vectoring,
//  central-angle vectoring); reset is synchronous and clears the valid chain, the queue and the tolerance
//  rsp_stall on a valid response freezes the back pipeline; the queue then fills and req_stall rises
//  csr_ready is always high; a write lands in the front's tolerance register
module great_circle_distance_and_course #(
   parameter int ANGLE_WIDTH   = 32,
   parameter int CORDIC_STAGES = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [ANGLE_WIDTH-1:0] req_lat_start,
   input  logic signed [ANGLE_WIDTH-1:0] req_lon_start,
   input  logic signed [ANGLE_WIDTH-1:0] req_lat_end,
   input  logic signed [ANGLE_WIDTH-1:0] req_lon_end,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [gcdc_pkg::DIST_W-1:0]   rsp_distance_nmi,
   output logic [ANGLE_WIDTH-1:0]        rsp_course_angle,
   output logic [1:0]                    rsp_course_case,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [gcdc_pkg::TOL_W-1:0]    csr_angle_tolerance
);
   import gcdc_pkg::*;

   localparam int AW = ANGLE_WIDTH;
   localparam int CW = $bits(cls_type);
   localparam int QW = 3 * AW + CW;

   // front -> queue
   logic                 f_valid;
   logic signed [AW-1:0] f_lat1, f_lat2, f_dlon;
   cls_type              f_cls;
   logic                 q_full;

   // queue -> back
   logic                 q_valid;
   logic                 q_take;
   logic [QW-1:0]        q_data;
   cls_type              q_cls;

   // configuration writes are always taken
   assign csr_ready = 1'b1;

   gcdc_front #(.ANGLE_WIDTH(AW)) u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_lat_start      (req_lat_start),
      .req_lon_start      (req_lon_start),
      .req_lat_end        (req_lat_end),
      .req_lon_end        (req_lon_end),
      .csr_write          (csr_valid && csr_ready),
      .csr_angle_tolerance(csr_angle_tolerance),
      .q_full             (q_full),
      .push_valid         (f_valid),
      .lat1               (f_lat1),
      .lat2               (f_lat2),
      .dlon               (f_dlon),
      .cls                (f_cls)
   );

   // classified request waits here until the back pipeline moves
   gcdc_queue #(.DATA_WIDTH(QW)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_valid(f_valid),
      .push_data ({f_lat1, f_lat2, f_dlon, f_cls}),
      .full      (q_full),
      .pop_take  (q_take),
      .pop_valid (q_valid),
      .pop_data  (q_data)
   );

   assign q_cls = cls_type'(q_data[CW-1:0]);

   gcdc_back #(.ANGLE_WIDTH(AW), .CORDIC_STAGES(CORDIC_STAGES)) u_back (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (q_valid),
      .in_take         (q_take),
      .lat1            (q_data[QW-1 -: AW]),
      .lat2            (q_data[QW-AW-1 -: AW]),
      .dlon            (q_data[CW +: AW]),
      .cls             (q_cls),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_distance_nmi(rsp_distance_nmi),
      .rsp_course_angle(rsp_course_angle),
      .rsp_course_case (rsp_course_case)
   );

endmodule

### rtl/gcdc_checker.sv
// port-level checks for the great-circle block, bound to the top level
`include "great_circle_distance_and_course_defines.svh"

module gcdc_checker #(
   parameter int ANGLE_WIDTH = 32
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic signed [ANGLE_WIDTH-1:0] req_lat_start,
   input logic signed [ANGLE_WIDTH-1:0] req_lon_start,
   input logic signed [ANGLE_WIDTH-1:0] req_lat_end,
   input logic signed [ANGLE_WIDTH-1:0] req_lon_end,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [gcdc_pkg::DIST_W-1:0]   rsp_distance_nmi,
   input logic [ANGLE_WIDTH-1:0]        rsp_course_angle,
   input logic [1:0]                    rsp_course_case,
   input logic                          csr_valid,
   input logic                          csr_ready,
   input logic [gcdc_pkg::TOL_W-1:0]    csr_angle_tolerance
);
   import gcdc_pkg::*;

   localparam logic [ANGLE_WIDTH-1:0] HALF_A = {1'b1, {(ANGLE_WIDTH-1){1'b0}}};

   // a stalled response holds
   `GCDC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_distance_nmi) && $stable(rsp_course_angle) && $stable(rsp_course_case))

   // coincident points report course zero
   `GCDC_ASSERT_IMPLY(a_coincide_course, clock, reset, rsp_valid && rsp_course_case == CASE_COINCIDE, rsp_course_angle == '0)

   // meridian course is due north or due south
   `GCDC_ASSERT_IMPLY(a_meridian_course, clock, reset, rsp_valid && rsp_course_case == CASE_MERIDIAN, rsp_course_angle == '0 || rsp_course_angle == HALF_A)

   // distance never exceeds half the circumference
   `GCDC_ASSERT_IMPLY(a_dist_range, clock, reset, rsp_valid, rsp_distance_nmi <= DIST_MAX)

endmodule

bind great_circle_distance_and_course gcdc_checker #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_checker (.*);
